// ===== rtl/core/lpbd_pkg.sv =====
// shared types, constants and commands for the lru page buffer directory
package lpbd_pkg;

  localparam int SLOTS  = 16;
  localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int RANK_W = IDX_W;
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int CAP_W  = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic [1:0] OP_FETCH  = 2'd0;
  localparam logic [1:0] OP_MARK   = 2'd1;
  localparam logic [1:0] OP_FLUSH  = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic KIND_WB  = 1'b0;
  localparam logic KIND_FIN = 1'b1;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [RANK_W-1:0] rank_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] page_id;
    logic        load_ok;
  } in_t;

  typedef struct packed {
    logic        item_kind;
    logic [31:0] page_out;
    logic        was_hit;
    logic        page_present;
    logic [31:0] hit_total;
    logic [31:0] miss_total;
    logic        last;
  } out_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_CAPTURE,
    CMD_HIT,
    CMD_MISS,
    CMD_INSERT,
    CMD_MARK,
    CMD_FLUSH_START,
    CMD_FLUSH_STEP,
    CMD_FIN_ZERO
  } cmd_e;

  typedef struct packed {
    logic [1:0] op;
    logic       hit;
    logic       scan_dirty;
    logic       scan_last;
    logic       out_free;
  } status_t;

endpackage

// ===== rtl/core/lpbd_datapath.sv =====
// slot directory, lru ranks, counters and result register
module lpbd_datapath (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  lpbd_pkg::cmd_e  cmd_i,
  output lpbd_pkg::status_t status_o,
  input  lpbd_pkg::in_t   in_data_i,
  input  logic            cfg_we_i,
  input  logic [4:0]      cfg_wdata_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output lpbd_pkg::out_t  out_data_o
);
  import lpbd_pkg::*;

  in_t                req_q;
  logic [31:0]        page_q [SLOTS];
  logic [SLOTS-1:0]   valid_q, valid_d;
  logic [SLOTS-1:0]   dirty_q, dirty_d;
  rank_t              rank_q [SLOTS];
  rank_t              rank_d [SLOTS];
  logic [31:0]        hits_q, hits_d, miss_q, miss_d;
  logic [CAP_W-1:0]   cap_q;
  idx_t               scan_q, scan_d;
  logic               out_valid_q, out_valid_d;
  out_t               out_q, out_d;

  logic               hit;
  idx_t               hit_idx, vic_idx, free_idx;
  logic               vic_found, has_free;
  cnt_t               occ, cap;
  logic               evict_due;
  logic               out_free;
  logic               ins_we;

  always_comb begin
    hit = 1'b0;
    hit_idx = '0;
    vic_found = 1'b0;
    vic_idx = '0;
    has_free = 1'b0;
    free_idx = '0;
    occ = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (valid_q[i] && page_q[i] == req_q.page_id) begin
        hit = 1'b1;
        hit_idx = idx_t'(i);
      end
      if (!valid_q[i]) begin
        has_free = 1'b1;
        free_idx = idx_t'(i);
      end
    end
    for (int i = 0; i < SLOTS; i++) begin
      occ = occ + cnt_t'(valid_q[i]);
    end
    if (cap_q == '0) begin
      cap = cnt_t'(1);
    end else if (int'(cap_q) > SLOTS) begin
      cap = cnt_t'(SLOTS);
    end else begin
      cap = cnt_t'(cap_q);
    end
    evict_due = (occ != '0) && (occ >= cap);
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (valid_q[i] && rank_q[i] == rank_t'(occ - cnt_t'(1))) begin
        vic_found = 1'b1;
        vic_idx = idx_t'(i);
      end
    end
  end

  assign out_free = !out_valid_q || out_ready_i;

  assign status_o.op         = req_q.op;
  assign status_o.hit        = hit;
  assign status_o.scan_dirty = valid_q[scan_q] && dirty_q[scan_q];
  assign status_o.scan_last  = (scan_q == idx_t'(SLOTS - 1));
  assign status_o.out_free   = out_free;

  always_comb begin
    valid_d = valid_q;
    dirty_d = dirty_q;
    rank_d = rank_q;
    hits_d = hits_q;
    miss_d = miss_q;
    scan_d = scan_q;
    ins_we = 1'b0;
    out_valid_d = out_ready_i ? 1'b0 : out_valid_q;
    out_d = out_q;
    unique case (cmd_i)
      CMD_HIT: begin
        hits_d = hits_q + 32'd1;
        for (int i = 0; i < SLOTS; i++) begin
          if (valid_q[i] && rank_q[i] < rank_q[hit_idx]) begin
            rank_d[i] = rank_q[i] + rank_t'(1);
          end
        end
        rank_d[hit_idx] = '0;
        out_valid_d = 1'b1;
        out_d = '{KIND_FIN, req_q.page_id, 1'b1, 1'b1, 32'd0, 32'd0, 1'b1};
      end
      CMD_MISS: begin
        miss_d = miss_q + 32'd1;
        if (evict_due && vic_found) begin
          valid_d[vic_idx] = 1'b0;
          dirty_d[vic_idx] = 1'b0;
          rank_d[vic_idx] = '0;
          if (dirty_q[vic_idx]) begin
            out_valid_d = 1'b1;
            out_d = '{KIND_WB, page_q[vic_idx], 1'b0, 1'b0, 32'd0, 32'd0, 1'b0};
          end
        end
      end
      CMD_INSERT: begin
        if (req_q.load_ok) begin
          for (int i = 0; i < SLOTS; i++) begin
            if (valid_q[i]) begin
              rank_d[i] = rank_q[i] + rank_t'(1);
            end
          end
          if (has_free) begin
            ins_we = 1'b1;
            valid_d[free_idx] = 1'b1;
            dirty_d[free_idx] = 1'b0;
            rank_d[free_idx] = '0;
          end
        end
        out_valid_d = 1'b1;
        out_d = '{KIND_FIN, req_q.page_id, 1'b0, req_q.load_ok, 32'd0, 32'd0, 1'b1};
      end
      CMD_MARK: begin
        if (hit) begin
          dirty_d[hit_idx] = 1'b1;
        end
        out_valid_d = 1'b1;
        out_d = '{KIND_FIN, req_q.page_id, 1'b0, hit, 32'd0, 32'd0, 1'b1};
      end
      CMD_FLUSH_START: begin
        scan_d = '0;
      end
      CMD_FLUSH_STEP: begin
        if (valid_q[scan_q] && dirty_q[scan_q]) begin
          out_valid_d = 1'b1;
          out_d = '{KIND_WB, page_q[scan_q], 1'b0, 1'b1, 32'd0, 32'd0, 1'b0};
        end
        dirty_d[scan_q] = 1'b0;
        scan_d = scan_q + idx_t'(1);
      end
      CMD_FIN_ZERO: begin
        out_valid_d = 1'b1;
        out_d = '{KIND_FIN, 32'd0, 1'b0, 1'b0, 32'd0, 32'd0, 1'b1};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      dirty_q <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        rank_q[i] <= '0;
      end
      hits_q <= '0;
      miss_q <= '0;
      cap_q <= CAP_RESET;
      scan_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      dirty_q <= dirty_d;
      rank_q <= rank_d;
      hits_q <= hits_d;
      miss_q <= miss_d;
      scan_q <= scan_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (cmd_i == CMD_CAPTURE) begin
      req_q <= in_data_i;
    end
    if (ins_we) begin
      page_q[free_idx] <= req_q.page_id;
    end
  end

  // totals only move while the result register is free, so live values match
  always_comb begin
    out_data_o = out_q;
    out_data_o.hit_total = hits_q;
    out_data_o.miss_total = miss_q;
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/core/lpbd_ctrl.sv =====
// sequencing state machine for the lru page buffer directory
module lpbd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  lpbd_pkg::status_t status_i,
  output lpbd_pkg::cmd_e    cmd_o
);
  import lpbd_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_INS   = 3'd2;
  localparam logic [2:0] S_FLUSH = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o = CMD_NONE;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o = CMD_CAPTURE;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (status_i.out_free) begin
          unique case (status_i.op)
            OP_FETCH: begin
              if (status_i.hit) begin
                cmd_o = CMD_HIT;
                state_d = S_IDLE;
              end else begin
                cmd_o = CMD_MISS;
                state_d = S_INS;
              end
            end
            OP_MARK: begin
              cmd_o = CMD_MARK;
              state_d = S_IDLE;
            end
            OP_FLUSH: begin
              cmd_o = CMD_FLUSH_START;
              state_d = S_FLUSH;
            end
            default: begin
              cmd_o = CMD_FIN_ZERO;
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_INS: begin
        if (status_i.out_free) begin
          cmd_o = CMD_INSERT;
          state_d = S_IDLE;
        end
      end
      S_FLUSH: begin
        if (!status_i.scan_dirty || status_i.out_free) begin
          cmd_o = CMD_FLUSH_STEP;
          if (status_i.scan_last) begin
            state_d = S_FIN;
          end
        end
      end
      S_FIN: begin
        if (status_i.out_free) begin
          cmd_o = CMD_FIN_ZERO;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/core/lru_page_buffer_directory_unit.sv =====
// top level of the lru page buffer directory
//  channel  | direction | handshake            | payload
//  in       | input     | in_valid_i/in_ready_o  | lpbd_pkg::in_t
//  out      | output    | out_valid_o/out_ready_i| lpbd_pkg::out_t
//  cfg      | input     | cfg_we_i             | cfg_wdata_i (pages_in_use)
// a hit, mark or unused op finishes in the exec state, a miss goes on to an insert state,
// a flush scans every slot and then finishes; the controller takes one request at a time
// each write-back or finish item waits while the result register is full
// reset clears valid, dirty, ranks and counters at once; no clearing pass
module lru_page_buffer_directory_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  lpbd_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output lpbd_pkg::out_t out_data_o,
  input  logic           cfg_we_i,
  input  logic [4:0]     cfg_wdata_i
);
  import lpbd_pkg::*;

  cmd_e    cmd;
  status_t status;

  lpbd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  lpbd_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== rtl/core/lpbd_checker.sv =====
// port-level checks for the lru page buffer directory
module lpbd_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input lpbd_pkg::out_t out_data_o,
  input logic           cfg_we_i
);
  import lpbd_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  a_last_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.item_kind == out_data_o.last))
    else $error("last flag does not match item kind");

  a_wb_no_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.item_kind == KIND_WB |-> !out_data_o.was_hit)
    else $error("write-back flagged as hit");

  a_one_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while another is in flight");

  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |-> in_ready_o && !out_valid_o)
    else $error("configuration written while a request is in flight");

endmodule

bind lru_page_buffer_directory_unit lpbd_checker u_chk (.*);

// ===== dv/lru_page_buffer_directory_unit_tb.sv =====
// testbench for the lru page buffer directory: directed and random requests checked against a model
`timescale 1ns / 1ps

module lru_page_buffer_directory_unit_tb;
  import lpbd_pkg::*;

  localparam int NSLOT = SLOTS;
  localparam int CYCLE_LIMIT = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_t out_data_o;
  logic cfg_we_i = 1'b0;
  logic [4:0] cfg_wdata_i = '0;

  lru_page_buffer_directory_unit DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o),
    .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i)
  );

  logic [31:0] dir_page [NSLOT];
  logic dir_valid [NSLOT];
  logic dir_dirty [NSLOT];
  int unsigned dir_rank [NSLOT];
  logic [31:0] hits, misses;
  logic [4:0] cap_reg;

  out_t expected_q[$];
  int errors = 0;
  int requests_sent = 0;
  int results_seen = 0;
  int send_idle = 0;
  int recv_idle = 0;
  int cycles = 0;
  logic [31:0] recent_q[$];

  function automatic out_t make_item(logic kind, logic [31:0] pg, logic h, logic pr,
                                     logic lst);
    out_t o;
    o.item_kind = kind;
    o.page_out = pg;
    o.was_hit = h;
    o.page_present = pr;
    o.hit_total = hits;
    o.miss_total = misses;
    o.last = lst;
    return o;
  endfunction

  task automatic predict_directory(in_t req);
    int s, n, cap, fs;
    s = -1;
    n = 0;
    fs = -1;
    for (int i = 0; i < NSLOT; i++) begin
      if (dir_valid[i] && dir_page[i] == req.page_id && s < 0) s = i;
      if (dir_valid[i]) n++;
    end
    if (req.op == OP_FETCH) begin
      if (s >= 0) begin
        hits++;
        for (int i = 0; i < NSLOT; i++)
          if (dir_valid[i] && dir_rank[i] < dir_rank[s]) dir_rank[i]++;
        dir_rank[s] = 0;
        expected_q.push_back(make_item(KIND_FIN, req.page_id, 1'b1, 1'b1, 1'b1));
      end else begin
        misses++;
        cap = (cap_reg == 0) ? 1 : (cap_reg > NSLOT) ? NSLOT : cap_reg;
        if (n >= cap && n > 0) begin
          for (int i = 0; i < NSLOT; i++) begin
            if (dir_valid[i] && dir_rank[i] == n - 1) begin
              if (dir_dirty[i])
                expected_q.push_back(make_item(KIND_WB, dir_page[i], 1'b0, 1'b0, 1'b0));
              dir_valid[i] = 1'b0;
              dir_dirty[i] = 1'b0;
              dir_rank[i] = 0;
              break;
            end
          end
        end
        if (req.load_ok) begin
          for (int i = 0; i < NSLOT; i++) begin
            if (!dir_valid[i]) begin
              if (fs < 0) fs = i;
            end else dir_rank[i]++;
          end
          if (fs >= 0) begin
            dir_valid[fs] = 1'b1;
            dir_dirty[fs] = 1'b0;
            dir_page[fs] = req.page_id;
            dir_rank[fs] = 0;
          end
        end
        expected_q.push_back(make_item(KIND_FIN, req.page_id, 1'b0, req.load_ok, 1'b1));
      end
    end else if (req.op == OP_MARK) begin
      if (s >= 0) dir_dirty[s] = 1'b1;
      expected_q.push_back(make_item(KIND_FIN, req.page_id, 1'b0, s >= 0, 1'b1));
    end else if (req.op == OP_FLUSH) begin
      for (int i = 0; i < NSLOT; i++) begin
        if (dir_valid[i] && dir_dirty[i])
          expected_q.push_back(make_item(KIND_WB, dir_page[i], 1'b0, 1'b1, 1'b0));
        dir_dirty[i] = 1'b0;
      end
      expected_q.push_back(make_item(KIND_FIN, 32'd0, 1'b0, 1'b0, 1'b1));
    end else begin
      expected_q.push_back(make_item(KIND_FIN, 32'd0, 1'b0, 1'b0, 1'b1));
    end
  endtask

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL lru_page_buffer_directory_unit");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk_i) begin
    out_t exp_item;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        $error("unexpected result %p", out_data_o);
        errors++;
      end else begin
        exp_item = expected_q.pop_front();
        if (out_data_o.item_kind !== exp_item.item_kind) begin
          $error("item_kind exp %0d got %0d", exp_item.item_kind, out_data_o.item_kind);
          errors++;
        end
        if (out_data_o.page_out !== exp_item.page_out) begin
          $error("page_out exp %h got %h", exp_item.page_out, out_data_o.page_out);
          errors++;
        end
        if (out_data_o.was_hit !== exp_item.was_hit) begin
          $error("was_hit exp %0d got %0d", exp_item.was_hit, out_data_o.was_hit);
          errors++;
        end
        if (out_data_o.page_present !== exp_item.page_present) begin
          $error("page_present exp %0d got %0d", exp_item.page_present,
                 out_data_o.page_present);
          errors++;
        end
        if (out_data_o.hit_total !== exp_item.hit_total) begin
          $error("hit_total exp %0d got %0d", exp_item.hit_total, out_data_o.hit_total);
          errors++;
        end
        if (out_data_o.miss_total !== exp_item.miss_total) begin
          $error("miss_total exp %0d got %0d", exp_item.miss_total, out_data_o.miss_total);
          errors++;
        end
        if (out_data_o.last !== exp_item.last) begin
          $error("last exp %0d got %0d", exp_item.last, out_data_o.last);
          errors++;
        end
      end
    end
  end

  task automatic send_request(logic [1:0] op, logic [31:0] pg, logic ok);
    in_t req;
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    req.op = op;
    req.page_id = pg;
    req.load_ok = ok;
    in_data_i <= req;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_directory(req);
    requests_sent++;
    if (op == OP_FETCH && ok) begin
      recent_q.push_back(pg);
      if (recent_q.size() > 24) void'(recent_q.pop_front());
    end
    @(negedge clk_i);
  endtask

  task automatic drain_and_write_cap(logic [4:0] val);
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (NSLOT + 8) @(negedge clk_i);
    cfg_wdata_i <= val;
    cfg_we_i <= 1'b1;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    cap_reg = val;
  endtask

  function automatic logic [31:0] pick_page();
    int r;
    r = $urandom_range(99);
    if (r < 60 && recent_q.size() > 0) return recent_q[$urandom_range(recent_q.size() - 1)];
    if (r < 90) return $urandom_range(40);
    return $urandom;
  endfunction

  task automatic test_directed();
    send_request(OP_MARK, 32'd5, 1'b1);
    send_request(OP_FLUSH, 32'd0, 1'b0);
    send_request(OP_FETCH, 32'hFFFFFFFF, 1'b1);
    send_request(OP_FETCH, 32'd0, 1'b1);
    send_request(OP_FETCH, 32'hFFFFFFFF, 1'b1);
    send_request(OP_FETCH, 32'd7, 1'b0);
    send_request(OP_MARK, 32'd0, 1'b0);
    send_request(OP_MARK, 32'hFFFFFFFF, 1'b1);
    send_request(OP_MARK, 32'd7, 1'b1);
    send_request(OP_UNUSED, 32'hA5A5A5A5, 1'b1);
    send_request(OP_FLUSH, 32'h12345678, 1'b1);
    drain_and_write_cap(5'd1);
    send_request(OP_MARK, 32'hFFFFFFFF, 1'b1);
    send_request(OP_FETCH, 32'd9, 1'b1);
    send_request(OP_FETCH, 32'd10, 1'b0);
    drain_and_write_cap(5'd0);
    send_request(OP_MARK, 32'd9, 1'b0);
    send_request(OP_FETCH, 32'd11, 1'b1);
    drain_and_write_cap(5'd31);
    for (int i = 0; i < 6; i++) send_request(OP_FETCH, 32'd20 + i, 1'b1);
  endtask

  task automatic test_random(int count, logic [4:0] cap);
    int r;
    drain_and_write_cap(cap);
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < 60) send_request(OP_FETCH, pick_page(), $urandom_range(9) != 0);
      else if (r < 88) send_request(OP_MARK, pick_page(), 1'($urandom_range(1)));
      else if (r < 97) send_request(OP_FLUSH, $urandom, 1'($urandom_range(1)));
      else send_request(OP_UNUSED, $urandom, 1'($urandom_range(1)));
    end
  endtask

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    cap_reg = CAP_RESET;
    hits = '0;
    misses = '0;
    for (int i = 0; i < NSLOT; i++) begin
      dir_page[i] = '0;
      dir_valid[i] = 1'b0;
      dir_dirty[i] = 1'b0;
      dir_rank[i] = 0;
    end
    @(negedge clk_i);
    send_idle = 36;
    recv_idle = 84;
    test_directed();
    test_random(60, 5'd16);
    test_random(60, 5'd3);
    send_idle = 84;
    recv_idle = 36;
    test_random(60, 5'd1);
    test_random(60, 5'd8);
    send_idle = 0;
    recv_idle = 0;
    test_random(70, 5'd31);
    test_random(40, 5'd2);
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (NSLOT + 8) @(negedge clk_i);
    $display("covered %0d requests and %0d results over capacities 0 to 31", requests_sent,
             results_seen);
    $display("fetch hits %0d, misses %0d", hits, misses);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("PASS lru_page_buffer_directory_unit");
    end else begin
      $display("FAIL lru_page_buffer_directory_unit");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/lpbd_pkg.sv
rtl/core/lpbd_datapath.sv
rtl/core/lpbd_ctrl.sv
rtl/core/lru_page_buffer_directory_unit.sv
rtl/core/lpbd_checker.sv
dv/lru_page_buffer_directory_unit_tb.sv
